// File: src/vtp_pkg.sv
// ============================================================================
// vtp_pkg
// Shared types, constants and arithmetic helpers for the vertex transform.
// ============================================================================
package vtp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 32;
    localparam int VP_W      = 13;
    localparam int DIV_STEPS = Q_W;
    localparam int PM_W      = 2 * Q_W - FRAC_BITS;

    typedef logic signed [Q_W-1:0] t_q;
    typedef t_q [3:0] t_vec4;

    localparam t_q Q_MAX = 32'sh7FFF_FFFF;
    localparam t_q Q_MIN = 32'sh8000_0000;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_VERTEX = 1'b1;

    typedef enum logic [2:0] {
        CFG_WORLD_X   = 3'd0,
        CFG_WORLD_Y   = 3'd1,
        CFG_WORLD_Z   = 3'd2,
        CFG_VDIST_H   = 3'd3,
        CFG_VDIST_V   = 3'd4,
        CFG_VP_WIDTH  = 3'd5,
        CFG_VP_HEIGHT = 3'd6
    } t_cfg_idx;

    // one lane of the restoring divider
    typedef struct packed {
        logic [Q_W-1:0] rem;
        logic [Q_W-1:0] nlo;
        logic [Q_W-1:0] quo;
        logic [Q_W-1:0] den;
    } t_dlane;

    // data riding alongside the divider
    typedef struct packed {
        t_q   depth;
        t_q   hom_w;
        logic zero;
        logic neg_x;
        logic ovf_x;
        logic nz_x;
        logic neg_y;
        logic ovf_y;
        logic nz_y;
    } t_side;

    function automatic t_q sat32(input logic signed [63:0] x);
        t_q r;
        if (x > 64'(Q_MAX)) begin
            r = Q_MAX;
        end else if (x < 64'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = x[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic t_dlane div_step(input t_dlane a);
        t_dlane     r;
        logic [Q_W:0] t;
        logic       qb;
        t  = {a.rem, a.nlo[Q_W-1]};
        qb = (t >= {1'b0, a.den});
        r  = a;
        if (qb) begin
            r.rem = Q_W'(t - {1'b0, a.den});
        end else begin
            r.rem = t[Q_W-1:0];
        end
        r.nlo = {a.nlo[Q_W-2:0], 1'b0};
        r.quo = {a.quo[Q_W-2:0], qb};
        return r;
    endfunction

    // signed quotient with saturation and the zero-depth rule
    function automatic t_q quo_fix(input logic [Q_W-1:0] q, input logic neg,
                                   input logic ovf, input logic nz, input logic zero);
        t_q r;
        if (zero) begin
            r = nz ? (neg ? Q_MIN : Q_MAX) : '0;
        end else if (ovf) begin
            r = neg ? Q_MIN : Q_MAX;
        end else if (neg) begin
            r = (q > {1'b1, {(Q_W-1){1'b0}}}) ? Q_MIN : t_q'(~q + 1'b1);
        end else begin
            r = q[Q_W-1] ? Q_MAX : t_q'(q);
        end
        return r;
    endfunction

endpackage

// File: src/vertex_transform_pipeline_top.sv
// ============================================================================
// vertex_transform_pipeline_top
// Q16.16 vertex transform: world translate, camera matrix, perspective divide
// and viewport mapping, fully pipelined.
// ============================================================================
// Stages: 4 transform stages, 2 projection stages, 32 divider stages,
//   quotient fixup, viewport product, output register.
// Throughput: one item per cycle while the skid slot is empty; the
//   32-stage divider sets the depth.
// Reset (synchronous, i_rst_n low): pipeline emptied, camera matrix zeroed,
//   world position 0, view distances 1.0, viewport 640 x 480.
module vertex_transform_pipeline_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [31:0]                 i_cfg_data,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_func,
    input  logic [3:0]                  i_coef_index,
    input  logic signed [31:0]          i_coef_value,
    input  logic signed [31:0]          i_vx,
    input  logic signed [31:0]          i_vy,
    input  logic signed [31:0]          i_vz,
    input  logic signed [31:0]          i_vw,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [31:0]          o_screen_x,
    output logic signed [31:0]          o_screen_y,
    output logic signed [31:0]          o_depth,
    output logic signed [31:0]          o_hom_w,
    output logic                        o_zero_depth
);

    localparam int W = vtp_pkg::Q_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    vtp_pkg::t_q                 r_world_x;
    vtp_pkg::t_q                 r_world_y;
    vtp_pkg::t_q                 r_world_z;
    vtp_pkg::t_q                 r_vdist_h;
    vtp_pkg::t_q                 r_vdist_v;
    logic [vtp_pkg::VP_W-1:0]    r_vp_w;
    logic [vtp_pkg::VP_W-1:0]    r_vp_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_world_x <= '0;
            r_world_y <= '0;
            r_world_z <= '0;
            r_vdist_h <= W'(1) <<< vtp_pkg::FRAC_BITS;
            r_vdist_v <= W'(1) <<< vtp_pkg::FRAC_BITS;
            r_vp_w    <= vtp_pkg::VP_W'(640);
            r_vp_h    <= vtp_pkg::VP_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vtp_pkg::CFG_WORLD_X:   r_world_x <= i_cfg_data;
                vtp_pkg::CFG_WORLD_Y:   r_world_y <= i_cfg_data;
                vtp_pkg::CFG_WORLD_Z:   r_world_z <= i_cfg_data;
                vtp_pkg::CFG_VDIST_H:   r_vdist_h <= i_cfg_data;
                vtp_pkg::CFG_VDIST_V:   r_vdist_v <= i_cfg_data;
                vtp_pkg::CFG_VP_WIDTH:  r_vp_w    <= i_cfg_data[vtp_pkg::VP_W-1:0];
                vtp_pkg::CFG_VP_HEIGHT: r_vp_h    <= i_cfg_data[vtp_pkg::VP_W-1:0];
                default: ;  // index 7 is not a register
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline enable: the whole pipe advances unless the skid slot is full
    // ------------------------------------------------------------------
    logic r_skid_valid;
    logic pipe_en;

    assign pipe_en    = !r_skid_valid;
    assign o_in_ready = pipe_en;

    // ------------------------------------------------------------------
    // translation and camera matrix
    // ------------------------------------------------------------------
    vtp_pkg::t_vec4 in_v;
    logic           cam_valid;
    vtp_pkg::t_vec4 cam;

    assign in_v = {i_vw, i_vz, i_vy, i_vx};

    vtp_xform u_xform (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (pipe_en),
        .i_valid      (i_in_valid),
        .i_func       (i_func),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_v          (in_v),
        .i_world_x    (r_world_x),
        .i_world_y    (r_world_y),
        .i_world_z    (r_world_z),
        .o_valid      (cam_valid),
        .o_cam        (cam)
    );

    // ------------------------------------------------------------------
    // projection: numerators scale*x, scale*y
    // ------------------------------------------------------------------
    logic                    r5_valid;
    logic signed [2*W-1:0]   r5_num_x;
    logic signed [2*W-1:0]   r5_num_y;
    vtp_pkg::t_q             r5_z;
    vtp_pkg::t_q             r5_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (pipe_en) begin
            r5_valid <= cam_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r5_num_x <= r_vdist_h * cam[0];
            r5_num_y <= r_vdist_v * cam[1];
            r5_z     <= cam[2];
            r5_w     <= cam[3];
        end
    end

    // magnitudes, signs and overflow check ahead of the divider.
    // |num| <= 2^62 fits 63 bits; the quotient fits 32 bits when the
    // numerator's high half stays below the divisor.
    logic [2*W-1:0]   mag_x;
    logic [2*W-1:0]   mag_y;
    logic [W-1:0]     mag_z;
    vtp_pkg::t_side   n6_side;

    assign mag_x = r5_num_x[2*W-1] ? (2*W)'(-r5_num_x) : r5_num_x;
    assign mag_y = r5_num_y[2*W-1] ? (2*W)'(-r5_num_y) : r5_num_y;
    assign mag_z = r5_z[W-1] ? W'(-r5_z) : r5_z;

    always_comb begin
        n6_side.depth = r5_z;
        n6_side.hom_w = r5_w;
        n6_side.zero  = (r5_z == '0);
        n6_side.neg_x = r5_num_x[2*W-1] ^ r5_z[W-1];
        n6_side.ovf_x = ({1'b0, mag_x[2*W-2:W]} >= mag_z);
        n6_side.nz_x  = (r5_num_x != '0);
        n6_side.neg_y = r5_num_y[2*W-1] ^ r5_z[W-1];
        n6_side.ovf_y = ({1'b0, mag_y[2*W-2:W]} >= mag_z);
        n6_side.nz_y  = (r5_num_y != '0);
    end

    logic               r6_valid;
    logic [2*W-2:0]     r6_mag_x;
    logic [2*W-2:0]     r6_mag_y;
    logic [W-1:0]       r6_mag_z;
    vtp_pkg::t_side     r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (pipe_en) begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r6_mag_x <= mag_x[2*W-2:0];
            r6_mag_y <= mag_y[2*W-2:0];
            r6_mag_z <= mag_z;
            r6_side  <= n6_side;
        end
    end

    // ------------------------------------------------------------------
    // perspective divide, both lanes share one pipeline of stages
    // ------------------------------------------------------------------
    logic             div_valid;
    logic [W-1:0]     div_qx;
    logic [W-1:0]     div_qy;
    vtp_pkg::t_side   div_side;

    vtp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r6_valid),
        .i_num_x (r6_mag_x),
        .i_den_x (r6_mag_z),
        .i_num_y (r6_mag_y),
        .i_den_y (r6_mag_z),
        .i_side  (r6_side),
        .o_valid (div_valid),
        .o_quo_x (div_qx),
        .o_quo_y (div_qy),
        .o_side  (div_side)
    );

    // quotient sign, saturation and zero-depth substitution
    logic           r7_valid;
    vtp_pkg::t_q    r7_px;
    vtp_pkg::t_q    r7_py;
    vtp_pkg::t_q    r7_depth;
    vtp_pkg::t_q    r7_hom_w;
    logic           r7_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (pipe_en) begin
            r7_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r7_px    <= vtp_pkg::quo_fix(div_qx, div_side.neg_x, div_side.ovf_x,
                                         div_side.nz_x, div_side.zero);
            r7_py    <= vtp_pkg::quo_fix(div_qy, div_side.neg_y, div_side.ovf_y,
                                         div_side.nz_y, div_side.zero);
            r7_depth <= div_side.depth;
            r7_hom_w <= div_side.hom_w;
            r7_zero  <= div_side.zero;
        end
    end

    // ------------------------------------------------------------------
    // viewport mapping
    // ------------------------------------------------------------------
    logic           fin_valid;
    vtp_pkg::t_q    fin_sx;
    vtp_pkg::t_q    fin_sy;
    vtp_pkg::t_q    fin_depth;
    vtp_pkg::t_q    fin_hom_w;
    logic           fin_zero;

    vtp_view u_view (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r7_valid),
        .i_px    (r7_px),
        .i_py    (r7_py),
        .i_depth (r7_depth),
        .i_hom_w (r7_hom_w),
        .i_zero  (r7_zero),
        .i_vp_w  (r_vp_w),
        .i_vp_h  (r_vp_h),
        .o_valid (fin_valid),
        .o_sx    (fin_sx),
        .o_sy    (fin_sy),
        .o_depth (fin_depth),
        .o_hom_w (fin_hom_w),
        .o_zero  (fin_zero)
    );

    // ------------------------------------------------------------------
    // output register plus one skid slot. A result that finds the output
    // register held parks in the skid slot; the pipe then freezes until
    // the slot drains, so no transfer is lost or doubled.
    // ------------------------------------------------------------------
    logic           r_out_valid;
    vtp_pkg::t_q    r_out_sx;
    vtp_pkg::t_q    r_out_sy;
    vtp_pkg::t_q    r_out_depth;
    vtp_pkg::t_q    r_out_hom_w;
    logic           r_out_zero;

    vtp_pkg::t_q    r_skid_sx;
    vtp_pkg::t_q    r_skid_sy;
    vtp_pkg::t_q    r_skid_depth;
    vtp_pkg::t_q    r_skid_hom_w;
    logic           r_skid_zero;

    logic           load_fin;
    logic           load_skid;
    logic           park;

    assign load_skid = r_skid_valid && i_out_ready;
    assign load_fin  = !r_skid_valid && fin_valid && (!r_out_valid || i_out_ready);
    assign park      = !r_skid_valid && fin_valid && r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (load_skid) begin
                r_skid_valid <= 1'b0;
            end else if (park) begin
                r_skid_valid <= 1'b1;
            end
            if (load_skid || load_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_skid) begin
            r_out_sx    <= r_skid_sx;
            r_out_sy    <= r_skid_sy;
            r_out_depth <= r_skid_depth;
            r_out_hom_w <= r_skid_hom_w;
            r_out_zero  <= r_skid_zero;
        end else if (load_fin) begin
            r_out_sx    <= fin_sx;
            r_out_sy    <= fin_sy;
            r_out_depth <= fin_depth;
            r_out_hom_w <= fin_hom_w;
            r_out_zero  <= fin_zero;
        end
        if (park) begin
            r_skid_sx    <= fin_sx;
            r_skid_sy    <= fin_sy;
            r_skid_depth <= fin_depth;
            r_skid_hom_w <= fin_hom_w;
            r_skid_zero  <= fin_zero;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_screen_x   = r_out_sx;
    assign o_screen_y   = r_out_sy;
    assign o_depth      = r_out_depth;
    assign o_hom_w      = r_out_hom_w;
    assign o_zero_depth = r_out_zero;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // skid slot only fills behind a held output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot full with output register empty");

    // a parked result freezes the pipe for the next cycle
    a_park_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        park |=> !o_in_ready)
        else $error("input accepted while a result sits in the skid slot");

    // zero-depth flag agrees with the reported depth
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_zero_depth == (o_depth == '0)))
        else $error("zero_depth flag disagrees with depth");

endmodule

// File: src/vtp_xform.sv
// ============================================================================
// vtp_xform
// World translation and camera matrix multiply; holds the camera matrix.
// ============================================================================
module vtp_xform (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic                 i_func,
    input  logic [3:0]           i_coef_index,
    input  vtp_pkg::t_q          i_coef_value,
    input  vtp_pkg::t_vec4       i_v,
    input  vtp_pkg::t_q          i_world_x,
    input  vtp_pkg::t_q          i_world_y,
    input  vtp_pkg::t_q          i_world_z,
    output logic                 o_valid,
    output vtp_pkg::t_vec4       o_cam
);

    // stage 1: translation products
    logic                    r1_valid;
    logic                    r1_func;
    logic [3:0]              r1_cidx;
    vtp_pkg::t_q             r1_cval;
    vtp_pkg::t_vec4          r1_v;
    logic signed [63:0]      r1_pr [3];
    logic signed [63:0]      n1_pr [3];

    // stage 2: translated vertex
    logic                    r2_valid;
    logic                    r2_func;
    logic [3:0]              r2_cidx;
    vtp_pkg::t_q             r2_cval;
    vtp_pkg::t_vec4          r2_t;
    vtp_pkg::t_vec4          n2_t;

    // stage 3: floored matrix products
    logic                              r3_valid;
    logic signed [vtp_pkg::PM_W-1:0]   r3_pm [16];
    logic signed [vtp_pkg::PM_W-1:0]   n3_pm [16];

    // stage 4: camera vertex
    logic                    r4_valid;
    vtp_pkg::t_vec4          r4_c;
    vtp_pkg::t_vec4          n4_c;

    vtp_pkg::t_q             r_mat [16];

    always_comb begin
        n1_pr[0] = i_v[3] * i_world_x;
        n1_pr[1] = i_v[3] * i_world_y;
        n1_pr[2] = i_v[3] * i_world_z;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_t[i] = vtp_pkg::sat32(64'(r1_v[i]) + (r1_pr[i] >>> vtp_pkg::FRAC_BITS));
        end
        n2_t[3] = r1_v[3];
    end

    always_comb begin
        logic signed [63:0] p;
        for (int k = 0; k < 16; k++) begin
            p        = r2_t[k / 4] * r_mat[k];
            n3_pm[k] = p[63:vtp_pkg::FRAC_BITS];
        end
    end

    always_comb begin
        logic signed [63:0] acc;
        for (int j = 0; j < 4; j++) begin
            acc = 64'(r3_pm[j]) + 64'(r3_pm[4 + j]) + 64'(r3_pm[8 + j])
                + 64'(r3_pm[12 + j]);
            n4_c[j] = vtp_pkg::sat32(acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid && (r2_func == vtp_pkg::FUNC_VERTEX);
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_func <= i_func;
            r1_cidx <= i_coef_index;
            r1_cval <= i_coef_value;
            r1_v    <= i_v;
            r1_pr   <= n1_pr;
            r2_func <= r1_func;
            r2_cidx <= r1_cidx;
            r2_cval <= r1_cval;
            r2_t    <= n2_t;
            r3_pm   <= n3_pm;
            r4_c    <= n4_c;
        end
    end

    // coefficient loads take effect where vertices read the matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) begin
                r_mat[k] <= '0;
            end
        end else if (i_en && r2_valid && (r2_func == vtp_pkg::FUNC_LOAD)) begin
            r_mat[r2_cidx] <= r2_cval;
        end
    end

    assign o_valid = r4_valid;
    assign o_cam   = r4_c;

endmodule

// File: src/vtp_div.sv
// ============================================================================
// vtp_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module vtp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [2*vtp_pkg::Q_W-2:0]     i_num_x,
    input  logic [vtp_pkg::Q_W-1:0]       i_den_x,
    input  logic [2*vtp_pkg::Q_W-2:0]     i_num_y,
    input  logic [vtp_pkg::Q_W-1:0]       i_den_y,
    input  vtp_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [vtp_pkg::Q_W-1:0]       o_quo_x,
    output logic [vtp_pkg::Q_W-1:0]       o_quo_y,
    output vtp_pkg::t_side                o_side
);

    localparam int N = vtp_pkg::DIV_STEPS;
    localparam int W = vtp_pkg::Q_W;

    logic             r_val [N];
    vtp_pkg::t_dlane  r_lx  [N];
    vtp_pkg::t_dlane  r_ly  [N];
    vtp_pkg::t_side   r_sd  [N];

    vtp_pkg::t_dlane  init_x;
    vtp_pkg::t_dlane  init_y;

    // remainder starts from the high half; no-overflow keeps it below den
    assign init_x = '{rem: {1'b0, i_num_x[2*W-2:W]}, nlo: i_num_x[W-1:0],
                      quo: '0, den: i_den_x};
    assign init_y = '{rem: {1'b0, i_num_y[2*W-2:W]}, nlo: i_num_y[W-1:0],
                      quo: '0, den: i_den_y};

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic            s_v;
        vtp_pkg::t_dlane s_x;
        vtp_pkg::t_dlane s_y;
        vtp_pkg::t_side  s_sd;

        if (k == 0) begin : g_first
            assign s_v  = i_valid;
            assign s_x  = init_x;
            assign s_y  = init_y;
            assign s_sd = i_side;
        end else begin : g_rest
            assign s_v  = r_val[k-1];
            assign s_x  = r_lx[k-1];
            assign s_y  = r_ly[k-1];
            assign s_sd = r_sd[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k] <= 1'b0;
            end else if (i_en) begin
                r_val[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lx[k] <= vtp_pkg::div_step(s_x);
                r_ly[k] <= vtp_pkg::div_step(s_y);
                r_sd[k] <= s_sd;
            end
        end
    end

    assign o_valid = r_val[N-1];
    assign o_quo_x = r_lx[N-1].quo;
    assign o_quo_y = r_ly[N-1].quo;
    assign o_side  = r_sd[N-1];

endmodule

// File: src/vtp_view.sv
// ============================================================================
// vtp_view
// Viewport mapping of projected x and y to screen coordinates.
// ============================================================================
module vtp_view (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  vtp_pkg::t_q                 i_px,
    input  vtp_pkg::t_q                 i_py,
    input  vtp_pkg::t_q                 i_depth,
    input  vtp_pkg::t_q                 i_hom_w,
    input  logic                        i_zero,
    input  logic [vtp_pkg::VP_W-1:0]    i_vp_w,
    input  logic [vtp_pkg::VP_W-1:0]    i_vp_h,
    output logic                        o_valid,
    output vtp_pkg::t_q                 o_sx,
    output vtp_pkg::t_q                 o_sy,
    output vtp_pkg::t_q                 o_depth,
    output vtp_pkg::t_q                 o_hom_w,
    output logic                        o_zero
);

    localparam int HW_W = vtp_pkg::VP_W + 1;
    localparam int PR_W = HW_W + vtp_pkg::Q_W;
    localparam int SM_W = PR_W + 2;

    logic signed [HW_W-1:0]  hw;
    logic signed [HW_W-1:0]  hh;
    logic signed [PR_W-1:0]  n_prx;
    logic signed [PR_W-1:0]  n_pry;

    logic                    r_valid;
    logic signed [HW_W-1:0]  r_hw;
    logic signed [HW_W-1:0]  r_hh;
    logic signed [PR_W-1:0]  r_prx;
    logic signed [PR_W-1:0]  r_pry;
    vtp_pkg::t_q             r_depth;
    vtp_pkg::t_q             r_hom_w;
    logic                    r_zero;

    logic signed [SM_W-1:0]  sum_x;
    logic signed [SM_W-1:0]  sum_y;

    // half extents: (size - 1), halving folded into the shifts below
    assign hw    = $signed({1'b0, i_vp_w}) - HW_W'(1);
    assign hh    = $signed({1'b0, i_vp_h}) - HW_W'(1);
    assign n_prx = hw * i_px;
    assign n_pry = hh * i_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hw    <= hw;
            r_hh    <= hh;
            r_prx   <= n_prx;
            r_pry   <= n_pry;
            r_depth <= i_depth;
            r_hom_w <= i_hom_w;
            r_zero  <= i_zero;
        end
    end

    assign sum_x = (SM_W'(r_hw) <<< (vtp_pkg::FRAC_BITS - 1)) + (SM_W'(r_prx) >>> 1);
    assign sum_y = (SM_W'(r_hh) <<< (vtp_pkg::FRAC_BITS - 1)) - (SM_W'(r_pry) >>> 1);

    assign o_valid = r_valid;
    assign o_sx    = vtp_pkg::sat32(64'(sum_x));
    assign o_sy    = vtp_pkg::sat32(64'(sum_y));
    assign o_depth = r_depth;
    assign o_hom_w = r_hom_w;
    assign o_zero  = r_zero;

endmodule

// File: tb/sv/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the vertex transform pipeline. A scoreboard class
// keeps its own copy of the camera matrix and registers, works out every
// screen point from the accepted inputs, and compares them in order with the
// results the block returns. Directed corner cases come first, then random
// phases under different register settings and randomized backpressure.
// ============================================================================
module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct {
        vtp_pkg::t_q sx;
        vtp_pkg::t_q sy;
        vtp_pkg::t_q depth;
        vtp_pkg::t_q hom_w;
        logic        zero;
    } t_screen_point;

    // ------------------------------------------------------------------------
    // Scoreboard: own model of the transform plus the queue of pending points
    // ------------------------------------------------------------------------
    class vertex_scoreboard;
        vtp_pkg::t_q   cam[16];
        vtp_pkg::t_q   world[3];
        vtp_pkg::t_q   vdist[2];
        logic [12:0]   vp_w, vp_h;
        t_screen_point pending_pts[$];
        int            mismatches, checked, vertices, loads;

        function new();
            foreach (cam[i]) cam[i] = '0;
            world = '{default: '0};
            vdist[0] = vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS);
            vdist[1] = vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS);
            vp_w = 13'd640;
            vp_h = 13'd480;
        endfunction

        function longint clamp_q(longint x);
            if (x > longint'(vtp_pkg::Q_MAX)) return longint'(vtp_pkg::Q_MAX);
            if (x < longint'(vtp_pkg::Q_MIN)) return longint'(vtp_pkg::Q_MIN);
            return x;
        endfunction

        function longint fx_mul(longint a, longint b);
            return (a * b) >>> vtp_pkg::FRAC_BITS;   // floor
        endfunction

        function longint persp(longint scale, longint c, longint z);
            longint num;
            num = scale * c;
            if (z == 0)
                return num > 0 ? longint'(vtp_pkg::Q_MAX)
                               : (num < 0 ? longint'(vtp_pkg::Q_MIN) : 0);
            return clamp_q(num / z);        // truncates toward zero
        endfunction

        function void write_reg(vtp_pkg::t_cfg_idx idx, logic [31:0] data);
            case (idx)
                vtp_pkg::CFG_WORLD_X:   world[0] = data;
                vtp_pkg::CFG_WORLD_Y:   world[1] = data;
                vtp_pkg::CFG_WORLD_Z:   world[2] = data;
                vtp_pkg::CFG_VDIST_H:   vdist[0] = data;
                vtp_pkg::CFG_VDIST_V:   vdist[1] = data;
                vtp_pkg::CFG_VP_WIDTH:  vp_w = data[12:0];
                vtp_pkg::CFG_VP_HEIGHT: vp_h = data[12:0];
                default: ;
            endcase
        endfunction

        // accepted input transfer
        function void note_input(logic fn, logic [3:0] ci, vtp_pkg::t_q cv,
                                 vtp_pkg::t_q x, vtp_pkg::t_q y,
                                 vtp_pkg::t_q z, vtp_pkg::t_q w);
            longint v[4], t[4], c[4];
            longint acc, px, py, hw, hh;
            t_screen_point p;
            if (fn == vtp_pkg::FUNC_LOAD) begin
                cam[ci] = cv;
                loads++;
                return;
            end
            vertices++;
            v[0] = x; v[1] = y; v[2] = z; v[3] = w;
            for (int i = 0; i < 3; i++) t[i] = clamp_q(v[i] + fx_mul(v[3], world[i]));
            t[3] = v[3];
            for (int j = 0; j < 4; j++) begin
                acc = 0;
                for (int i = 0; i < 4; i++) acc += fx_mul(t[i], cam[i*4+j]);
                c[j] = clamp_q(acc);
            end
            px = persp(vdist[0], c[0], c[2]);
            py = persp(vdist[1], c[1], c[2]);
            hw = longint'(vp_w) - 1;
            hh = longint'(vp_h) - 1;
            p.sx    = vtp_pkg::t_q'(clamp_q(hw * (longint'(1) <<< (vtp_pkg::FRAC_BITS-1))
                                            + ((hw * px) >>> 1)));
            p.sy    = vtp_pkg::t_q'(clamp_q(hh * (longint'(1) <<< (vtp_pkg::FRAC_BITS-1))
                                            - ((hh * py) >>> 1)));
            p.depth = vtp_pkg::t_q'(c[2]);
            p.hom_w = vtp_pkg::t_q'(c[3]);
            p.zero  = (c[2] == 0);
            pending_pts.push_back(p);
        endfunction

        // accepted result transfer
        function void check_result(vtp_pkg::t_q sx, vtp_pkg::t_q sy, vtp_pkg::t_q d,
                                   vtp_pkg::t_q hw, logic zd);
            t_screen_point e;
            if (pending_pts.size() == 0) begin
                $error("unexpected result sx=%0d sy=%0d", sx, sy);
                mismatches++;
                return;
            end
            e = pending_pts.pop_front();
            checked++;
            if (sx !== e.sx) begin
                $error("screen_x exp %0d got %0d", e.sx, sx); mismatches++;
            end
            if (sy !== e.sy) begin
                $error("screen_y exp %0d got %0d", e.sy, sy); mismatches++;
            end
            if (d !== e.depth) begin
                $error("depth exp %0d got %0d", e.depth, d); mismatches++;
            end
            if (hw !== e.hom_w) begin
                $error("hom_w exp %0d got %0d", e.hom_w, hw); mismatches++;
            end
            if (zd !== e.zero) begin
                $error("zero_depth exp %0d got %0d", e.zero, zd); mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_func = vtp_pkg::FUNC_LOAD;
    logic [3:0]  i_coef_index = '0;
    vtp_pkg::t_q i_coef_value = '0;
    vtp_pkg::t_q i_vx = '0, i_vy = '0, i_vz = '0, i_vw = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    vtp_pkg::t_q o_screen_x, o_screen_y, o_depth, o_hom_w;
    logic        o_zero_depth;

    vertex_transform_pipeline_top dut (.*);

    vertex_scoreboard sb = new();

    bit no_idle = 1'b0;     // both sides run flat out while set
    int hold_off = 0;       // receiver stall length requested by stimulus
    int quiet_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random backpressure, plus one long hold-off counted here
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                hold_left = hold_off;
                hold_off  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_idle || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // Result monitor; sampled values are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_screen_x, o_screen_y, o_depth, o_hom_w, o_zero_depth);
    end

    // Watchdog: any transfer on either side, or a register write, resets the count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", sb.pending_pts.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_item(logic fn, logic [3:0] ci, vtp_pkg::t_q cv,
                             vtp_pkg::t_q x, vtp_pkg::t_q y,
                             vtp_pkg::t_q z, vtp_pkg::t_q w);
        i_func       <= fn;
        i_coef_index <= ci;
        i_coef_value <= cv;
        i_vx <= x; i_vy <= y; i_vz <= z; i_vw <= w;
        i_in_valid   <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(fn, ci, cv, x, y, z, w);
        // random one-cycle gap after about a quarter of transfers, unless no_idle is set
        if (!no_idle && $urandom_range(0, 99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic load_coef(int idx, vtp_pkg::t_q val);
        send_item(vtp_pkg::FUNC_LOAD, 4'(idx), val, vtp_pkg::t_q'($urandom),
                  vtp_pkg::t_q'($urandom), vtp_pkg::t_q'($urandom),
                  vtp_pkg::t_q'($urandom));
    endtask

    task automatic send_vertex(vtp_pkg::t_q x, vtp_pkg::t_q y,
                               vtp_pkg::t_q z, vtp_pkg::t_q w);
        send_item(vtp_pkg::FUNC_VERTEX, 4'($urandom), vtp_pkg::t_q'($urandom),
                  x, y, z, w);
    endtask

    // drain results; loads leave no result, so let the pipe empty too
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_pts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(vtp_pkg::t_cfg_idx idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(vtp_pkg::t_q wx, vtp_pkg::t_q wy, vtp_pkg::t_q wz,
                            vtp_pkg::t_q vh, vtp_pkg::t_q vv,
                            logic [31:0] w, logic [31:0] h);
        write_reg(vtp_pkg::CFG_WORLD_X, wx);
        write_reg(vtp_pkg::CFG_WORLD_Y, wy);
        write_reg(vtp_pkg::CFG_WORLD_Z, wz);
        write_reg(vtp_pkg::CFG_VDIST_H, vh);
        write_reg(vtp_pkg::CFG_VDIST_V, vv);
        write_reg(vtp_pkg::CFG_VP_WIDTH, w);
        write_reg(vtp_pkg::CFG_VP_HEIGHT, h);
    endtask

    // mix of magnitudes: full range, modest values, and the corners
    function automatic vtp_pkg::t_q rand_q();
        case ($urandom_range(0, 5))
            0, 1: return vtp_pkg::t_q'($urandom);
            2, 3: return vtp_pkg::t_q'(int'($urandom_range(0, 32'h0020_0000))
                                       - 32'h0010_0000);
            4:    return vtp_pkg::t_q'(int'($urandom_range(0, 32'h4000_0000))
                                       - 32'h2000_0000);
            default: begin
                case ($urandom_range(0, 4))
                    0: return vtp_pkg::Q_MAX;
                    1: return vtp_pkg::Q_MIN;
                    2: return '0;
                    3: return vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS);
                    default: return vtp_pkg::t_q'(-1);
                endcase
            end
        endcase
    endfunction

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 15)
                load_coef($urandom_range(0, 15), rand_q());
            else
                send_vertex(rand_q(), rand_q(), rand_q(),
                            ($urandom_range(0, 3) == 0) ? rand_q()
                                : vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero matrix first, then identity, then corners
        send_vertex(vtp_pkg::Q_MAX, vtp_pkg::Q_MIN, '0,
                    vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS));
        for (int i = 0; i < 4; i++)
            load_coef(i * 5, vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS));
        send_vertex(vtp_pkg::t_q'(3 << vtp_pkg::FRAC_BITS),
                    vtp_pkg::t_q'(-2 << vtp_pkg::FRAC_BITS),
                    vtp_pkg::t_q'(4 << vtp_pkg::FRAC_BITS),
                    vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS));
        // saturation everywhere
        send_vertex(vtp_pkg::Q_MAX, vtp_pkg::Q_MAX, vtp_pkg::Q_MAX, vtp_pkg::Q_MAX);
        send_vertex(vtp_pkg::Q_MIN, vtp_pkg::Q_MIN, vtp_pkg::Q_MIN, vtp_pkg::Q_MIN);
        // zero depth, both signs
        send_vertex(vtp_pkg::t_q'(5 << vtp_pkg::FRAC_BITS),
                    vtp_pkg::t_q'(-5 << vtp_pkg::FRAC_BITS), '0,
                    vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS));
        send_vertex('0, '0, '0, '0);                      // zero depth, zero numerator
        // w of zero, floor rounding
        send_vertex(vtp_pkg::t_q'(-7), vtp_pkg::t_q'(9), vtp_pkg::t_q'(-1), '0);
        load_coef(15, vtp_pkg::Q_MIN);
        load_coef(1, vtp_pkg::Q_MAX);
        send_vertex(vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS),
                    vtp_pkg::t_q'(2 << vtp_pkg::FRAC_BITS),
                    vtp_pkg::t_q'(-3 << vtp_pkg::FRAC_BITS),
                    vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS));
        wait_idle();

        // Extremes of the registers, viewport sizes of 0 and 1 included
        set_regs(vtp_pkg::Q_MAX, vtp_pkg::Q_MIN, vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS),
                 vtp_pkg::Q_MIN, vtp_pkg::Q_MAX, 32'd0, 32'd1);
        send_vertex(vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS),
                    vtp_pkg::t_q'(-1 << vtp_pkg::FRAC_BITS),
                    vtp_pkg::t_q'(2 << vtp_pkg::FRAC_BITS),
                    vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS));
        send_vertex(vtp_pkg::Q_MAX, vtp_pkg::Q_MIN, '0, vtp_pkg::Q_MIN);
        send_vertex(vtp_pkg::t_q'(-3), vtp_pkg::t_q'(3),
                    vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS),
                    vtp_pkg::t_q'(-1 << vtp_pkg::FRAC_BITS));
        random_phase(90);
        wait_idle();

        // 4096 x 4096 viewport, modest translation; no idling on either side
        set_regs(vtp_pkg::t_q'(10 << vtp_pkg::FRAC_BITS),
                 vtp_pkg::t_q'(-4 << vtp_pkg::FRAC_BITS),
                 vtp_pkg::t_q'(100 << vtp_pkg::FRAC_BITS),
                 vtp_pkg::t_q'(256 << vtp_pkg::FRAC_BITS),
                 vtp_pkg::t_q'(1 << (vtp_pkg::FRAC_BITS - 1)), 32'd4096, 32'd4096);
        no_idle = 1'b1;
        random_phase(110);
        no_idle = 1'b0;

        // Sender pauses until every outstanding point has come back
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_pts.size() != 0) @(posedge i_clk);

        // Long receiver hold-off while the sender keeps pushing
        hold_off = 400;
        random_phase(120);
        wait_idle();

        // Random register values, widest 13-bit width, back to random gaps
        set_regs(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), 32'd8191,
                 32'($urandom_range(1, 4096)));
        random_phase(90);
        wait_idle();

        set_regs(rand_q(), rand_q(), rand_q(), vtp_pkg::t_q'(1 << vtp_pkg::FRAC_BITS),
                 vtp_pkg::t_q'(-1 << vtp_pkg::FRAC_BITS), 32'd640, 32'd480);
        random_phase(90);

        wait_idle();
        $display("covered %0d vertices and %0d coefficient loads; %0d points checked",
                 sb.vertices, sb.loads, sb.checked);
        $display("register sets: reset values, extremes, large viewport, random");
        if (sb.mismatches == 0 && sb.pending_pts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
